### rtl/sdh_pkg.sv
// Shared types and constants for the SD card SPI host engine.
`default_nettype none

package sdh_pkg;

  localparam int unsigned IN_DATA_W  = 64;
  localparam int unsigned OUT_DATA_W = 64;
  localparam int unsigned CMD_W      = 3;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [31:0] MAX_COUNT = 32'd65535;

  localparam logic [CMD_W-1:0] CMD_INIT  = 3'd0;
  localparam logic [CMD_W-1:0] CMD_READ  = 3'd1;
  localparam logic [CMD_W-1:0] CMD_WRITE = 3'd2;
  localparam logic [CMD_W-1:0] CMD_RX    = 3'd3;
  localparam logic [CMD_W-1:0] CMD_WDATA = 3'd4;
  localparam logic [CMD_W-1:0] CMD_TICK  = 3'd5;

  localparam logic [2:0] ERR_NONE     = 3'd0;
  localparam logic [2:0] ERR_NO_CARD  = 3'd1;
  localparam logic [2:0] ERR_ECHO     = 3'd2;
  localparam logic [2:0] ERR_INIT     = 3'd3;
  localparam logic [2:0] ERR_BUSY     = 3'd4;
  localparam logic [2:0] ERR_DATA     = 3'd5;
  localparam logic [2:0] ERR_REJECTED = 3'd6;

  localparam logic [CFG_IDX_W-1:0] CFG_READY_TO   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TOKEN_TO   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_INIT_TO    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_IDLE_ATT   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_RESP_POLLS = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_RETRY_DLY  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_PWR_DLY    = 3'd6;

  localparam logic [7:0] TOK_START   = 8'hFE;
  localparam logic [7:0] TOK_MULTI   = 8'hFC;
  localparam logic [7:0] TOK_STOP    = 8'hFD;
  localparam logic [7:0] CRC_CMD0    = 8'h95;
  localparam logic [7:0] CRC_CMD8    = 8'h87;
  localparam logic [7:0] CRC_DUMMY   = 8'h01;
  localparam logic [7:0] IDLE_BYTE   = 8'hFF;
  localparam logic [4:0] DRESP_MASK_OK = 5'h05;

  typedef struct packed {
    logic [15:0] ready_to;
    logic [15:0] token_to;
    logic [15:0] init_to;
    logic [7:0]  idle_att;
    logic [7:0]  resp_polls;
    logic [7:0]  retry_dly;
    logic [7:0]  pwr_dly;
  } cfg_t;

  typedef struct packed {
    logic        has;
    logic        txv;
    logic [7:0]  tx;
    logic        cs;
    logic        slow;
    logic        rv;
    logic [7:0]  rb;
    logic        ww;
    logic        done;
    logic        succ;
    logic [2:0]  err;
    logic        rdy;
    logic [31:0] cap;
  } res_t;

endpackage

`default_nettype wire

### rtl/sdh_cfg.sv
// Configuration register file of the SD host engine.
`default_nettype none

module sdh_cfg (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_valid_i,
  output logic                                cfg_ready_o,
  input  wire logic [sdh_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [sdh_pkg::CFG_DATA_W-1:0] cfg_data_i,
  output sdh_pkg::cfg_t                       cfg_o
);

  sdh_pkg::cfg_t cfg_q, cfg_d;

  assign cfg_ready_o = 1'b1;
  assign cfg_o       = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (cfg_index_i)
        sdh_pkg::CFG_READY_TO:   cfg_d.ready_to   = cfg_data_i;
        sdh_pkg::CFG_TOKEN_TO:   cfg_d.token_to   = cfg_data_i;
        sdh_pkg::CFG_INIT_TO:    cfg_d.init_to    = cfg_data_i;
        sdh_pkg::CFG_IDLE_ATT:   cfg_d.idle_att   = cfg_data_i[7:0];
        sdh_pkg::CFG_RESP_POLLS: cfg_d.resp_polls = cfg_data_i[7:0];
        sdh_pkg::CFG_RETRY_DLY:  cfg_d.retry_dly  = cfg_data_i[7:0];
        sdh_pkg::CFG_PWR_DLY:    cfg_d.pwr_dly    = cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.ready_to   <= 16'd500;
      cfg_q.token_to   <= 16'd200;
      cfg_q.init_to    <= 16'd1000;
      cfg_q.idle_att   <= 8'd10;
      cfg_q.resp_polls <= 8'd10;
      cfg_q.retry_dly  <= 8'd20;
      cfg_q.pwr_dly    <= 8'd10;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

`default_nettype wire

### rtl/sdh_core.sv
// Protocol sequencer of the SD host engine: one transaction step per fire.
`default_nettype none

module sdh_core (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      fire_i,
  input  wire logic [sdh_pkg::CMD_W-1:0] cmd_i,
  input  wire logic [31:0]               lba_i,
  input  wire logic [15:0]               count_i,
  input  wire logic [7:0]                rx_i,
  input  wire logic [7:0]                wbyte_i,
  input  wire sdh_pkg::cfg_t             cfg_i,
  output sdh_pkg::res_t                  res_o
);

  typedef enum logic [5:0] {
    P_IDLE, P_FR_CSH, P_FR_RDY, P_FR_SEND, P_FR_STUFF, P_FR_POLL,
    P_I_PWR, P_I_CLK, P_I_RDLY, P_I_RCLK, P_I_R7, P_I_OCR, P_TOK, P_CSD, P_RDATA,
    P_W_RDY, P_W_TOK, P_W_REQ, P_W_DATA, P_W_TAIL, P_W_FIN,
    R_CMD0, R_CMD8, R_A41V2, R_CMD58, R_V1PROBE, R_V1LOOP, R_CMD16, R_CMD9,
    R_RDCMD, R_CMD12, R_A23, R_WRCMD
  } phase_e;

  function automatic logic [7:0] frame_byte(input logic [5:0] c, input logic [31:0] a,
                                            input logic [2:0] i);
    logic [7:0] b;
    case (i)
      3'd0:    b = {2'b01, c};
      3'd1:    b = a[31:24];
      3'd2:    b = a[23:16];
      3'd3:    b = a[15:8];
      3'd4:    b = a[7:0];
      default: b = (c == 6'd0) ? sdh_pkg::CRC_CMD0 :
                   ((c == 6'd8) ? sdh_pkg::CRC_CMD8 : sdh_pkg::CRC_DUMMY);
    endcase
    return b;
  endfunction

  phase_e      phase_q, phase_d, ret_q, ret_d, is_ret;
  logic [5:0]  fcmd_q, fcmd_d, is_cmd, effc;
  logic [31:0] farg_q, farg_d, is_arg;
  logic        app_q, app_d;
  logic [9:0]  bidx_q, bidx_d;
  logic [7:0]  pcnt_q, pcnt_d, att_q, att_d;
  logic [15:0] ms_q, ms_d, pms_q, pms_d;
  logic [31:0] ocr_q, ocr_d;
  logic [7:0]  csd_q [16];
  logic        csd_we;
  logic [15:0] blk_q, blk_d;
  logic [31:0] addr_q, addr_d;
  logic        hc_q, hc_d, rdy_q, rdy_d, cs_q, cs_d, slow_q, slow_d, fail_q, fail_d;
  logic [31:0] cap_q, cap_d, cap_csd;
  logic [2:0]  err_q, err_d;

  logic        do_cr, do_issue, do_begin, do_fin, fin_ok, do_initok, do_wfail, do_rv, do_ww;
  logic        snd;
  logic [7:0]  snd_b, cr_r1, wtok;
  logic [2:0]  fin_code, wf_code;

  logic [21:0] v2_size;
  logic [22:0] v2_sz1;
  logic [11:0] v1_size;
  logic [12:0] v1_sz1;
  logic [2:0]  v1_m;
  logic [3:0]  v1_rb, v1_sh;

  // CSD capacity decode
  always_comb begin
    v2_size = {csd_q[7][5:0], csd_q[8], csd_q[9]};
    v2_sz1  = {1'b0, v2_size} + 23'd1;
    v1_size = {csd_q[6][1:0], csd_q[7], csd_q[8][7:6]};
    v1_sz1  = {1'b0, v1_size} + 13'd1;
    v1_m    = {csd_q[9][1:0], csd_q[10][7]};
    v1_rb   = csd_q[5][3:0];
    v1_sh   = 4'(5'({2'b0, v1_m}) + 5'({1'b0, v1_rb}) - 5'd7);
    if (csd_q[0][7:6] == 2'b01) begin
      cap_csd = {v2_sz1[21:0], 10'b0};
    end else if (v1_rb < 4'd9) begin
      cap_csd = 32'd0;
    end else begin
      cap_csd = {19'b0, v1_sz1} << v1_sh;
    end
  end

  assign wtok = (fcmd_q == 6'd24) ? sdh_pkg::TOK_START :
                (((blk_q == 16'd0) || fail_q) ? sdh_pkg::TOK_STOP : sdh_pkg::TOK_MULTI);

  always_comb begin
    phase_d = phase_q; ret_d = ret_q; fcmd_d = fcmd_q; farg_d = farg_q; app_d = app_q;
    bidx_d = bidx_q; pcnt_d = pcnt_q; att_d = att_q; ms_d = ms_q; pms_d = pms_q;
    ocr_d = ocr_q; blk_d = blk_q; addr_d = addr_q; hc_d = hc_q; rdy_d = rdy_q;
    cs_d = cs_q; slow_d = slow_q; fail_d = fail_q; cap_d = cap_q; err_d = err_q;
    csd_we = 1'b0;
    do_cr = 1'b0; cr_r1 = 8'h00; do_issue = 1'b0; is_cmd = 6'd0; is_arg = 32'd0;
    is_ret = P_IDLE; do_begin = 1'b0; do_fin = 1'b0; fin_ok = 1'b0;
    fin_code = sdh_pkg::ERR_NONE; do_initok = 1'b0; do_wfail = 1'b0;
    wf_code = sdh_pkg::ERR_NONE; do_rv = 1'b0; do_ww = 1'b0;
    snd = 1'b0; snd_b = sdh_pkg::IDLE_BYTE;
    effc = app_q ? 6'd55 : fcmd_q;
    res_o = '0;

    case (cmd_i)
      sdh_pkg::CMD_TICK: begin
        if (ms_d != 16'd0) ms_d = ms_q - 16'd1;
        if (pms_d != 16'd0) pms_d = pms_q - 16'd1;
        if (ms_d == 16'd0 && phase_q == P_I_PWR) begin
          bidx_d = '0; cs_d = 1'b0; phase_d = P_I_CLK; snd = 1'b1;
        end else if (ms_d == 16'd0 && phase_q == P_I_RDLY) begin
          bidx_d = '0; cs_d = 1'b0; phase_d = P_I_RCLK; snd = 1'b1;
        end
      end
      sdh_pkg::CMD_WDATA: begin
        if (phase_q == P_W_REQ) begin
          phase_d = P_W_DATA; snd = 1'b1; snd_b = wbyte_i;
        end
      end
      sdh_pkg::CMD_INIT: begin
        if (phase_q == P_IDLE) begin
          rdy_d = 1'b0; err_d = sdh_pkg::ERR_NONE; slow_d = 1'b1; cs_d = 1'b0;
          fail_d = 1'b0; ms_d = {8'd0, cfg_i.pwr_dly}; phase_d = P_I_PWR;
          if (cfg_i.pwr_dly == 8'd0) begin
            bidx_d = '0; phase_d = P_I_CLK; snd = 1'b1;
          end
        end
      end
      sdh_pkg::CMD_READ, sdh_pkg::CMD_WRITE: begin
        if (phase_q == P_IDLE) begin
          if (!rdy_q || count_i == 16'd0 || {16'd0, count_i} > sdh_pkg::MAX_COUNT) begin
            do_fin = 1'b1; fin_ok = 1'b0; err_d = sdh_pkg::ERR_REJECTED;
          end else begin
            err_d = sdh_pkg::ERR_NONE; fail_d = 1'b0;
            addr_d = hc_q ? lba_i : {lba_i[22:0], 9'b0};
            blk_d = count_i; cs_d = 1'b1; do_issue = 1'b1; is_arg = addr_d;
            if (cmd_i == sdh_pkg::CMD_READ) begin
              is_cmd = (count_i == 16'd1) ? 6'd17 : 6'd18; is_ret = R_RDCMD;
            end else if (count_i == 16'd1) begin
              is_cmd = 6'd24; is_ret = R_WRCMD;
            end else begin
              is_cmd = 6'd23; is_arg = {16'd0, count_i}; is_ret = R_A23;
            end
          end
        end
      end
      sdh_pkg::CMD_RX: begin
        case (phase_q)
          P_FR_CSH: begin
            cs_d = 1'b1; pms_d = cfg_i.ready_to; phase_d = P_FR_RDY; snd = 1'b1;
          end
          P_FR_RDY: begin
            if (rx_i == sdh_pkg::IDLE_BYTE || (pms_q == 16'd0 && effc == 6'd0)) begin
              bidx_d = '0; phase_d = P_FR_SEND; snd = 1'b1;
              snd_b = frame_byte(effc, app_q ? 32'd0 : farg_q, 3'd0);
            end else if (pms_q == 16'd0) begin
              err_d = sdh_pkg::ERR_BUSY; do_cr = 1'b1; cr_r1 = sdh_pkg::IDLE_BYTE;
            end else begin
              snd = 1'b1;
            end
          end
          P_FR_SEND: begin
            bidx_d = bidx_q + 10'd1;
            if (bidx_d < 10'd6) begin
              snd = 1'b1; snd_b = frame_byte(effc, app_q ? 32'd0 : farg_q, bidx_d[2:0]);
            end else if (effc == 6'd12) begin
              phase_d = P_FR_STUFF; snd = 1'b1;
            end else begin
              pcnt_d = cfg_i.resp_polls; phase_d = P_FR_POLL; snd = 1'b1;
            end
          end
          P_FR_STUFF: begin
            pcnt_d = cfg_i.resp_polls; phase_d = P_FR_POLL; snd = 1'b1;
          end
          P_FR_POLL: begin
            if (rx_i[7]) begin
              pcnt_d = pcnt_q - 8'd1;
              if (pcnt_d != 8'd0) snd = 1'b1;
              else begin do_cr = 1'b1; cr_r1 = rx_i; end
            end else begin
              do_cr = 1'b1; cr_r1 = rx_i;
            end
          end
          P_I_CLK: begin
            bidx_d = bidx_q + 10'd1;
            if (bidx_d < 10'd16) snd = 1'b1;
            else begin
              cs_d = 1'b1; att_d = 8'd0;
              if (att_d < cfg_i.idle_att) begin
                do_issue = 1'b1; is_cmd = 6'd0; is_ret = R_CMD0;
              end else begin
                do_fin = 1'b1; fin_code = sdh_pkg::ERR_NO_CARD;
              end
            end
          end
          P_I_RCLK: begin
            bidx_d = bidx_q + 10'd1;
            if (bidx_d < 10'd3) snd = 1'b1;
            else begin
              cs_d = 1'b1; att_d = att_q + 8'd1;
              if (att_d < cfg_i.idle_att) begin
                do_issue = 1'b1; is_cmd = 6'd0; is_ret = R_CMD0;
              end else begin
                do_fin = 1'b1; fin_code = sdh_pkg::ERR_NO_CARD;
              end
            end
          end
          P_I_R7, P_I_OCR: begin
            ocr_d = {ocr_q[23:0], rx_i};
            bidx_d = bidx_q + 10'd1;
            if (bidx_d < 10'd4) snd = 1'b1;
            else if (phase_q == P_I_R7) begin
              if (ocr_d[15:8] != 8'h01 || ocr_d[7:0] != 8'hAA) begin
                do_fin = 1'b1; fin_code = sdh_pkg::ERR_ECHO;
              end else begin
                ms_d = cfg_i.init_to; do_issue = 1'b1; is_cmd = 6'd41;
                is_arg = 32'h4000_0000; is_ret = R_A41V2;
              end
            end else begin
              hc_d = ocr_d[30]; do_issue = 1'b1; is_cmd = 6'd9; is_ret = R_CMD9;
            end
          end
          P_TOK: begin
            if (rx_i == sdh_pkg::IDLE_BYTE && pms_q != 16'd0) snd = 1'b1;
            else begin
              bidx_d = '0;
              if (fcmd_q == 6'd9) begin
                if (rx_i == sdh_pkg::TOK_START) begin phase_d = P_CSD; snd = 1'b1; end
                else do_initok = 1'b1;
              end else if (rx_i == sdh_pkg::TOK_START) begin
                phase_d = P_RDATA; snd = 1'b1;
              end else if (fcmd_q == 6'd17) begin
                do_fin = 1'b1;
              end else begin
                fail_d = 1'b1;
                if (err_q == sdh_pkg::ERR_NONE) err_d = sdh_pkg::ERR_DATA;
                do_issue = 1'b1; is_cmd = 6'd12; is_ret = R_CMD12;
              end
            end
          end
          P_CSD: begin
            csd_we = (bidx_q < 10'd16);
            bidx_d = bidx_q + 10'd1;
            if (bidx_d < 10'd18) snd = 1'b1;
            else begin cap_d = cap_csd; do_initok = 1'b1; end
          end
          P_RDATA: begin
            do_rv = (bidx_q < 10'd512);
            bidx_d = bidx_q + 10'd1;
            if (bidx_d < 10'd514) snd = 1'b1;
            else begin
              blk_d = blk_q - 16'd1;
              if (fcmd_q == 6'd17) begin
                do_fin = 1'b1; fin_ok = 1'b1;
              end else if (blk_d != 16'd0) begin
                pms_d = cfg_i.token_to; phase_d = P_TOK; snd = 1'b1;
              end else begin
                do_issue = 1'b1; is_cmd = 6'd12; is_ret = R_CMD12;
              end
            end
          end
          P_W_RDY: begin
            if (rx_i == sdh_pkg::IDLE_BYTE) begin
              phase_d = P_W_TOK; snd = 1'b1; snd_b = wtok;
            end else if (pms_q == 16'd0) begin
              do_wfail = 1'b1; wf_code = sdh_pkg::ERR_BUSY;
            end else begin
              snd = 1'b1;
            end
          end
          P_W_TOK: begin
            if (wtok == sdh_pkg::TOK_STOP) begin
              if (fail_q) do_fin = 1'b1;
              else begin pms_d = cfg_i.ready_to; phase_d = P_W_FIN; snd = 1'b1; end
            end else begin
              bidx_d = '0; phase_d = P_W_REQ; do_ww = 1'b1;
            end
          end
          P_W_DATA: begin
            bidx_d = bidx_q + 10'd1;
            if (bidx_d < 10'd512) begin
              phase_d = P_W_REQ; do_ww = 1'b1;
            end else begin
              phase_d = P_W_TAIL; snd = 1'b1;
            end
          end
          P_W_TAIL: begin
            if (bidx_q < 10'd514) begin
              bidx_d = bidx_q + 10'd1; snd = 1'b1;
            end else if (rx_i[4:0] == sdh_pkg::DRESP_MASK_OK) begin
              blk_d = blk_q - 16'd1;
              if (fcmd_q == 6'd24) begin
                pms_d = cfg_i.ready_to; phase_d = P_W_FIN; snd = 1'b1;
              end else begin
                pms_d = cfg_i.ready_to; phase_d = P_W_RDY; snd = 1'b1;
              end
            end else begin
              do_wfail = 1'b1; wf_code = sdh_pkg::ERR_DATA;
            end
          end
          P_W_FIN: begin
            if (rx_i == sdh_pkg::IDLE_BYTE || pms_q == 16'd0) begin
              do_fin = 1'b1; fin_ok = 1'b1;
            end else begin
              snd = 1'b1;
            end
          end
          default: ;
        endcase
      end
      default: ;
    endcase

    // write block failure
    if (do_wfail) begin
      if (err_d == sdh_pkg::ERR_NONE) err_d = wf_code;
      fail_d = 1'b1;
      if (wtok == sdh_pkg::TOK_MULTI) begin
        pms_d = cfg_i.ready_to; phase_d = P_W_RDY; snd = 1'b1;
      end else begin
        do_fin = 1'b1;
      end
    end

    // R1 response handling, app prefix first
    if (do_cr) begin
      if (app_q && cr_r1 <= 8'd1) begin
        app_d = 1'b0; do_begin = 1'b1;
      end else begin
        app_d = 1'b0;
        case (ret_q)
          R_CMD0: begin
            if (cr_r1 == 8'd1) begin
              do_issue = 1'b1; is_cmd = 6'd8; is_arg = 32'h0000_01AA; is_ret = R_CMD8;
            end else begin
              ms_d = {8'd0, cfg_i.retry_dly}; phase_d = P_I_RDLY;
              if (cfg_i.retry_dly == 8'd0) begin
                bidx_d = '0; cs_d = 1'b0; phase_d = P_I_RCLK; snd = 1'b1;
              end
            end
          end
          R_CMD8: begin
            if (cr_r1 == 8'd1) begin
              bidx_d = '0; ocr_d = '0; phase_d = P_I_R7; snd = 1'b1;
            end else begin
              do_issue = 1'b1; is_cmd = 6'd41; is_ret = R_V1PROBE;
            end
          end
          R_A41V2: begin
            if (cr_r1 == 8'd0) begin
              do_issue = 1'b1; is_cmd = 6'd58; is_ret = R_CMD58;
            end else if (ms_d == 16'd0) begin
              do_fin = 1'b1; fin_code = sdh_pkg::ERR_INIT;
            end else begin
              do_issue = 1'b1; is_cmd = 6'd41; is_arg = 32'h4000_0000; is_ret = R_A41V2;
            end
          end
          R_CMD58: begin
            if (cr_r1 != 8'd0) begin
              do_fin = 1'b1; fin_code = sdh_pkg::ERR_INIT;
            end else begin
              bidx_d = '0; ocr_d = '0; phase_d = P_I_OCR; snd = 1'b1;
            end
          end
          R_V1PROBE: begin
            ms_d = cfg_i.init_to; do_issue = 1'b1; is_ret = R_V1LOOP;
            is_cmd = (cr_r1 <= 8'd1) ? 6'd41 : 6'd1;
          end
          R_V1LOOP: begin
            if (cr_r1 == 8'd0) begin
              do_issue = 1'b1; is_cmd = 6'd16; is_arg = 32'd512; is_ret = R_CMD16;
            end else if (ms_d == 16'd0) begin
              do_fin = 1'b1; fin_code = sdh_pkg::ERR_INIT;
            end else begin
              do_issue = 1'b1; is_cmd = fcmd_q; is_ret = R_V1LOOP;
            end
          end
          R_CMD16: begin
            if (cr_r1 != 8'd0) begin
              do_fin = 1'b1; fin_code = sdh_pkg::ERR_INIT;
            end else begin
              hc_d = 1'b0; do_issue = 1'b1; is_cmd = 6'd9; is_ret = R_CMD9;
            end
          end
          R_CMD9: begin
            if (cr_r1 == 8'd0) begin
              pms_d = cfg_i.token_to; phase_d = P_TOK; snd = 1'b1;
            end else begin
              do_initok = 1'b1;
            end
          end
          R_RDCMD: begin
            if (cr_r1 != 8'd0) do_fin = 1'b1;
            else begin pms_d = cfg_i.token_to; phase_d = P_TOK; snd = 1'b1; end
          end
          R_CMD12: begin
            do_fin = 1'b1; fin_ok = !fail_d;
          end
          R_A23: begin
            do_issue = 1'b1; is_cmd = 6'd25; is_arg = addr_q; is_ret = R_WRCMD;
          end
          R_WRCMD: begin
            if (cr_r1 != 8'd0) do_fin = 1'b1;
            else begin pms_d = cfg_i.ready_to; phase_d = P_W_RDY; snd = 1'b1; end
          end
          default: do_fin = 1'b1;
        endcase
      end
    end

    if (do_initok) begin
      do_fin = 1'b1; fin_ok = 1'b1;
    end

    if (do_issue) begin
      fcmd_d = is_cmd; farg_d = is_arg; ret_d = is_ret;
      app_d = (is_cmd == 6'd41) || (is_cmd == 6'd23);
      do_begin = 1'b1;
    end

    if (do_begin) begin
      bidx_d = '0;
      if (!app_d && fcmd_d == 6'd12) begin
        phase_d = P_FR_SEND; snd = 1'b1;
        snd_b = frame_byte(fcmd_d, farg_d, 3'd0);
      end else begin
        cs_d = 1'b0; phase_d = P_FR_CSH; snd = 1'b1;
      end
    end

    if (do_fin) begin
      if (fin_ok) err_d = sdh_pkg::ERR_NONE;
      else if (fin_code != sdh_pkg::ERR_NONE) err_d = fin_code;
      else if (err_d == sdh_pkg::ERR_NONE) err_d = sdh_pkg::ERR_DATA;
      if (!(cmd_i != sdh_pkg::CMD_RX && err_d == sdh_pkg::ERR_REJECTED && !fin_ok
            && phase_q == P_IDLE)) begin
        cs_d = 1'b0; snd = 1'b1; snd_b = sdh_pkg::IDLE_BYTE; phase_d = P_IDLE;
      end
    end

    res_o.has  = snd | do_rv | do_ww | do_fin;
    res_o.txv  = snd;
    res_o.tx   = snd ? snd_b : 8'h00;
    res_o.cs   = cs_d;
    res_o.slow = slow_d;
    res_o.rv   = do_rv;
    res_o.rb   = do_rv ? rx_i : 8'h00;
    res_o.ww   = do_ww;
    res_o.done = do_fin;
    res_o.succ = do_fin & fin_ok;

    if (do_initok) begin
      slow_d = 1'b0; rdy_d = 1'b1;
    end

    res_o.err = err_d;
    res_o.rdy = rdy_d;
    res_o.cap = cap_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= P_IDLE; ret_q <= P_IDLE; fcmd_q <= '0; farg_q <= '0; app_q <= 1'b0;
      bidx_q <= '0; pcnt_q <= '0; att_q <= '0; ms_q <= '0; pms_q <= '0; ocr_q <= '0;
      blk_q <= '0; addr_q <= '0; hc_q <= 1'b0; rdy_q <= 1'b0; cap_q <= '0;
      err_q <= sdh_pkg::ERR_NONE; cs_q <= 1'b0; slow_q <= 1'b1; fail_q <= 1'b0;
    end else if (fire_i) begin
      phase_q <= phase_d; ret_q <= ret_d; fcmd_q <= fcmd_d; farg_q <= farg_d;
      app_q <= app_d; bidx_q <= bidx_d; pcnt_q <= pcnt_d; att_q <= att_d;
      ms_q <= ms_d; pms_q <= pms_d; ocr_q <= ocr_d; blk_q <= blk_d; addr_q <= addr_d;
      hc_q <= hc_d; rdy_q <= rdy_d; cap_q <= cap_d; err_q <= err_d; cs_q <= cs_d;
      slow_q <= slow_d; fail_q <= fail_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire_i && csd_we) begin
      csd_q[bidx_q[3:0]] <= rx_i;
    end
  end

`ifndef SYNTHESIS
  a_ww_waits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire_i && res_o.ww) |=> (phase_q == P_W_REQ))
    else $error("write data request without waiting phase");
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire_i && res_o.done) |=> (phase_q == P_IDLE))
    else $error("request ended but engine not idle");
  a_succ_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire_i && res_o.succ) |-> (res_o.err == sdh_pkg::ERR_NONE))
    else $error("success reported with an error code");
  a_rdata_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == P_RDATA) |-> (bidx_q < 10'd514))
    else $error("read block index overrun");
`endif

endmodule

`default_nettype wire

### rtl/sd_card_spi_host_engine.sv
// SD card SPI-mode host engine top level: input and output stages around the sequencer.
//
// Usage: every transaction on the slave stream is one step: tuser selects init, read,
// write, card byte (echo of the last byte shifted), write data byte or millisecond tick;
// tdata carries lba, block_count, rx_byte and write_byte. A step yields zero or one
// result transaction on the master stream: a byte to shift (tx_valid/tx_byte with chip
// select and clock rate), a read data byte, a request for the next write byte, or the
// end of a request (tlast) with success and error code. Card status fields ride along.
// Configuration writes use the cfg channel (always ready); the user must make them
// while idle, the block itself does not enforce it. A step passes the input register,
// then the result register. One step per cycle while the receiver does not stall; a
// real link runs one step per SPI byte.
// When the receiver stalls, the result register holds and the input register fills,
// then s_axis_tready_o drops until the result is taken.
// Reset clears all control state: engine idle, card not ready, slow clock, no select,
// configuration at its defaults. No clearing pass is needed.
`default_nettype none

module sd_card_spi_host_engine (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            s_axis_tvalid_i,
  output logic                                 s_axis_tready_o,
  // lba[31:0], block_count[47:32], rx_byte[55:48], write_byte[63:56]
  input  wire logic [sdh_pkg::IN_DATA_W-1:0]   s_axis_tdata_i,
  // command[2:0]
  input  wire logic [sdh_pkg::CMD_W-1:0]       s_axis_tuser_i,
  output logic                                 m_axis_tvalid_o,
  input  wire logic                            m_axis_tready_i,
  // tx_valid[0], tx_byte[8:1], chip_select[9], slow_clock[10], read_valid[11],
  // read_byte[19:12], write_wanted[20], success[21], error_code[24:22],
  // card_up[25], capacity_blocks[57:26], zero[63:58]
  output logic [sdh_pkg::OUT_DATA_W-1:0]       m_axis_tdata_o,
  // done_res
  output logic                                 m_axis_tlast_o,
  input  wire logic                            cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  wire logic [sdh_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  wire logic [sdh_pkg::CFG_DATA_W-1:0]  cfg_data_i
);

  sdh_pkg::cfg_t cfg;
  sdh_pkg::res_t res;

  logic                           in_v_q;
  logic [sdh_pkg::CMD_W-1:0]      in_cmd_q;
  logic [sdh_pkg::IN_DATA_W-1:0]  in_data_q;
  logic                           out_v_q;
  sdh_pkg::res_t                  out_q;
  logic                           core_fire;

  assign core_fire       = in_v_q && (!out_v_q || m_axis_tready_i);
  assign s_axis_tready_o = !in_v_q || core_fire;

  sdh_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  sdh_core u_core (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .fire_i  (core_fire),
    .cmd_i   (in_cmd_q),
    .lba_i   (in_data_q[31:0]),
    .count_i (in_data_q[47:32]),
    .rx_i    (in_data_q[55:48]),
    .wbyte_i (in_data_q[63:56]),
    .cfg_i   (cfg),
    .res_o   (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      if (s_axis_tvalid_i && s_axis_tready_o) begin
        in_v_q <= 1'b1;
      end else if (core_fire) begin
        in_v_q <= 1'b0;
      end
      if (core_fire) begin
        out_v_q <= res.has;
      end else if (m_axis_tready_i) begin
        out_v_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid_i && s_axis_tready_o) begin
      in_cmd_q  <= s_axis_tuser_i;
      in_data_q <= s_axis_tdata_i;
    end
    if (core_fire && res.has) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid_o = out_v_q;
  assign m_axis_tlast_o  = out_q.done;
  assign m_axis_tdata_o  = {6'd0, out_q.cap, out_q.rdy, out_q.err, out_q.succ, out_q.ww,
                            out_q.rb, out_q.rv, out_q.slow, out_q.cs, out_q.tx, out_q.txv};

endmodule

`default_nettype wire

### tb/sv/testbench.sv
// Self-checking testbench for the SD card SPI host engine: card emulation, prediction, checks.
`timescale 1ns / 100ps

module testbench;

  typedef enum logic [5:0] {
    PH_IDLE, PH_FR_CSH, PH_FR_RDY, PH_FR_SEND, PH_FR_STUFF, PH_FR_POLL,
    PH_I_PWR, PH_I_CLK, PH_I_RDLY, PH_I_RCLK, PH_I_R7, PH_I_OCR, PH_TOK, PH_CSD, PH_RDATA,
    PH_W_RDY, PH_W_TOK, PH_W_REQ, PH_W_DATA, PH_W_TAIL, PH_W_FIN,
    RT_CMD0, RT_CMD8, RT_A41V2, RT_CMD58, RT_V1PROBE, RT_V1LOOP, RT_CMD16, RT_CMD9,
    RT_RDCMD, RT_CMD12, RT_A23, RT_WRCMD
  } phase_e;

  typedef struct {
    logic [2:0]  cmd;
    logic [31:0] lba;
    logic [15:0] cnt;
    logic [7:0]  rx;
    logic [7:0]  wb;
  } step_t;

  localparam int unsigned N_STEPS     = 1250;
  localparam int unsigned CYCLE_LIMIT = 600000;
  localparam int unsigned SETTLE      = 8;
  localparam int unsigned IDX_W       = sdh_pkg::CFG_IDX_W;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_valid = 1'b0;
  logic s_ready;
  logic [sdh_pkg::IN_DATA_W-1:0] s_data = '0;
  logic [sdh_pkg::CMD_W-1:0] s_user = '0;
  logic m_valid;
  logic m_ready = 1'b0;
  logic [sdh_pkg::OUT_DATA_W-1:0] m_data;
  logic m_last;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [sdh_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [sdh_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  sd_card_spi_host_engine u_top (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .s_axis_tvalid_i(s_valid), .s_axis_tready_o(s_ready),
    .s_axis_tdata_i(s_data), .s_axis_tuser_i(s_user),
    .m_axis_tvalid_o(m_valid), .m_axis_tready_i(m_ready),
    .m_axis_tdata_o(m_data), .m_axis_tlast_o(m_last),
    .cfg_valid_i(cfg_valid), .cfg_ready_o(cfg_ready),
    .cfg_index_i(cfg_index), .cfg_data_i(cfg_data)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  step_t step_q[$];
  sdh_pkg::res_t expect_q[$];
  int unsigned err_cnt = 0;
  int unsigned cycles = 0;
  int unsigned n_done = 0, n_rd = 0, n_wr = 0, n_ok = 0;

  // engine copy
  logic [15:0] c_rdy_to, c_tok_to, c_init_to;
  logic [7:0]  c_att, c_polls, c_rdly, c_pdly;
  phase_e      ph, ret;
  logic [5:0]  fcmd;
  logic [31:0] farg;
  logic        app;
  logic [15:0] bidx;
  logic [7:0]  pcnt, att;
  logic [15:0] msc, pms;
  logic [31:0] ocr;
  logic [7:0]  csd[16];
  logic [15:0] bleft;
  logic [31:0] caddr;
  logic        hc, rdyf, cs, slow, rfail;
  logic [31:0] cap;
  logic [2:0]  errc;
  sdh_pkg::res_t r;

  function automatic void eng_reset();
    c_rdy_to = 500; c_tok_to = 200; c_init_to = 1000;
    c_att = 10; c_polls = 10; c_rdly = 20; c_pdly = 10;
    ph = PH_IDLE; ret = PH_IDLE; fcmd = 0; farg = 0; app = 0; bidx = 0; pcnt = 0;
    att = 0; msc = 0; pms = 0; ocr = 0; bleft = 0; caddr = 0; hc = 0; rdyf = 0;
    cap = 0; errc = sdh_pkg::ERR_NONE; cs = 0; slow = 1; rfail = 0;
    for (int i = 0; i < 16; i++) csd[i] = 0;
  endfunction

  function automatic void send(logic [7:0] b);
    r.has = 1; r.txv = 1; r.tx = b; r.cs = cs; r.slow = slow;
  endfunction

  function automatic void clk_ph(phase_e p);
    ph = p; send(sdh_pkg::IDLE_BYTE);
  endfunction

  function automatic logic [5:0] eff_cmd();
    return app ? 6'd55 : fcmd;
  endfunction

  function automatic logic [7:0] frame_byte(logic [15:0] i);
    logic [5:0] c;
    logic [31:0] a;
    c = eff_cmd();
    a = app ? 32'd0 : farg;
    case (i)
      0: return {2'b01, c};
      1: return a[31:24];
      2: return a[23:16];
      3: return a[15:8];
      4: return a[7:0];
      default: return c == 0 ? sdh_pkg::CRC_CMD0 :
                      (c == 8 ? sdh_pkg::CRC_CMD8 : sdh_pkg::CRC_DUMMY);
    endcase
  endfunction

  function automatic void frame_begin();
    bidx = 0;
    if (eff_cmd() == 12) begin
      ph = PH_FR_SEND; send(frame_byte(0));
    end else begin
      cs = 0; clk_ph(PH_FR_CSH);
    end
  endfunction

  function automatic void issue(logic [5:0] c, logic [31:0] a, phase_e rp);
    fcmd = c; farg = a; app = (c == 41 || c == 23); ret = rp;
    frame_begin();
  endfunction

  function automatic void close_req(logic ok, logic [2:0] code);
    r.has = 1; r.done = 1; r.succ = ok;
    if (ok) errc = sdh_pkg::ERR_NONE;
    else if (code != sdh_pkg::ERR_NONE) errc = code;
    else if (errc == sdh_pkg::ERR_NONE) errc = sdh_pkg::ERR_DATA;
    cs = 0; send(sdh_pkg::IDLE_BYTE); ph = PH_IDLE;
  endfunction

  function automatic void init_ok();
    close_req(1, sdh_pkg::ERR_NONE); slow = 0; rdyf = 1;
  endfunction

  function automatic void enter_clocks(phase_e p);
    bidx = 0; cs = 0; clk_ph(p);
  endfunction

  function automatic void try_cmd0();
    if (att < c_att) issue(0, 0, RT_CMD0);
    else close_req(0, sdh_pkg::ERR_NO_CARD);
  endfunction

  function automatic void start_token();
    pms = c_tok_to; clk_ph(PH_TOK);
  endfunction

  function automatic void begin_block();
    pms = c_rdy_to; clk_ph(PH_W_RDY);
  endfunction

  function automatic logic [7:0] wr_token();
    if (fcmd == 24) return sdh_pkg::TOK_START;
    return (bleft == 0 || rfail) ? sdh_pkg::TOK_STOP : sdh_pkg::TOK_MULTI;
  endfunction

  function automatic void wblock_fail(logic [2:0] code);
    logic [7:0] tok;
    tok = wr_token();
    if (errc == sdh_pkg::ERR_NONE) errc = code;
    rfail = 1;
    if (tok == sdh_pkg::TOK_MULTI) begin_block();
    else close_req(0, sdh_pkg::ERR_NONE);
  endfunction

  function automatic void decode_csd();
    logic [31:0] sz, m, rb;
    if (csd[0][7:6] == 2'd1) begin
      sz = {10'd0, csd[7][5:0], csd[8], csd[9]};
      cap = (sz + 1) * 32'd1024;
    end else begin
      sz = {20'd0, csd[6][1:0], csd[7], csd[8][7:6]};
      m = {29'd0, csd[9][1:0], csd[10][7]};
      rb = {28'd0, csd[5][3:0]};
      cap = (sz + 1) * (32'd1 << (m + 2)) * ((32'd1 << rb) / 32'd512);
    end
  endfunction

  function automatic void resume(logic [7:0] r1);
    case (ret)
      RT_CMD0: begin
        if (r1 == 1) issue(8, 32'h1AA, RT_CMD8);
        else begin
          msc = c_rdly; ph = PH_I_RDLY;
          if (msc == 0) enter_clocks(PH_I_RCLK);
        end
      end
      RT_CMD8: begin
        if (r1 == 1) begin
          bidx = 0; ocr = 0; clk_ph(PH_I_R7);
        end else issue(41, 0, RT_V1PROBE);
      end
      RT_A41V2: begin
        if (r1 == 0) issue(58, 0, RT_CMD58);
        else if (msc == 0) close_req(0, sdh_pkg::ERR_INIT);
        else issue(41, 32'h4000_0000, RT_A41V2);
      end
      RT_CMD58: begin
        if (r1 != 0) close_req(0, sdh_pkg::ERR_INIT);
        else begin
          bidx = 0; ocr = 0; clk_ph(PH_I_OCR);
        end
      end
      RT_V1PROBE: begin
        msc = c_init_to; issue(r1 <= 1 ? 6'd41 : 6'd1, 0, RT_V1LOOP);
      end
      RT_V1LOOP: begin
        if (r1 == 0) issue(16, 512, RT_CMD16);
        else if (msc == 0) close_req(0, sdh_pkg::ERR_INIT);
        else issue(fcmd, 0, RT_V1LOOP);
      end
      RT_CMD16: begin
        if (r1 != 0) close_req(0, sdh_pkg::ERR_INIT);
        else begin
          hc = 0; issue(9, 0, RT_CMD9);
        end
      end
      RT_CMD9: if (r1 == 0) start_token(); else init_ok();
      RT_RDCMD: if (r1 != 0) close_req(0, sdh_pkg::ERR_NONE); else start_token();
      RT_CMD12: close_req(!rfail, sdh_pkg::ERR_NONE);
      RT_A23: issue(25, caddr, RT_WRCMD);
      RT_WRCMD: if (r1 != 0) close_req(0, sdh_pkg::ERR_NONE); else begin_block();
      default: close_req(0, sdh_pkg::ERR_NONE);
    endcase
  endfunction

  function automatic void cmd_result(logic [7:0] r1);
    if (app) begin
      app = 0;
      if (r1 <= 1) begin
        frame_begin();
        return;
      end
    end
    resume(r1);
  endfunction

  function automatic void on_card_byte(logic [7:0] rx);
    case (ph)
      PH_FR_CSH: begin
        cs = 1; pms = c_rdy_to; clk_ph(PH_FR_RDY);
      end
      PH_FR_RDY: begin
        if (rx == 8'hFF || (pms == 0 && eff_cmd() == 0)) begin
          bidx = 0; ph = PH_FR_SEND; send(frame_byte(0));
        end else if (pms == 0) begin
          errc = sdh_pkg::ERR_BUSY; cmd_result(8'hFF);
        end else clk_ph(PH_FR_RDY);
      end
      PH_FR_SEND: begin
        bidx++;
        if (bidx < 6) send(frame_byte(bidx));
        else if (eff_cmd() == 12) clk_ph(PH_FR_STUFF);
        else begin
          pcnt = c_polls; clk_ph(PH_FR_POLL);
        end
      end
      PH_FR_STUFF: begin
        pcnt = c_polls; clk_ph(PH_FR_POLL);
      end
      PH_FR_POLL: begin
        if (rx[7]) begin
          pcnt = pcnt - 1;
          if (pcnt != 0) begin
            clk_ph(PH_FR_POLL);
            return;
          end
        end
        cmd_result(rx);
      end
      PH_I_CLK: begin
        bidx++;
        if (bidx < 16) clk_ph(PH_I_CLK);
        else begin
          cs = 1; att = 0; try_cmd0();
        end
      end
      PH_I_RCLK: begin
        bidx++;
        if (bidx < 3) clk_ph(PH_I_RCLK);
        else begin
          cs = 1; att++; try_cmd0();
        end
      end
      PH_I_R7, PH_I_OCR: begin
        ocr = {ocr[23:0], rx};
        bidx++;
        if (bidx < 4) clk_ph(ph);
        else if (ph == PH_I_R7) begin
          if (ocr[15:8] != 8'h01 || ocr[7:0] != 8'hAA) close_req(0, sdh_pkg::ERR_ECHO);
          else begin
            msc = c_init_to; issue(41, 32'h4000_0000, RT_A41V2);
          end
        end else begin
          hc = ocr[30]; issue(9, 0, RT_CMD9);
        end
      end
      PH_TOK: begin
        if (rx == 8'hFF && pms != 0) begin
          clk_ph(PH_TOK);
          return;
        end
        bidx = 0;
        if (fcmd == 9) begin
          if (rx == sdh_pkg::TOK_START) clk_ph(PH_CSD); else init_ok();
        end else if (rx == sdh_pkg::TOK_START) clk_ph(PH_RDATA);
        else if (fcmd == 17) close_req(0, sdh_pkg::ERR_NONE);
        else begin
          rfail = 1;
          if (errc == sdh_pkg::ERR_NONE) errc = sdh_pkg::ERR_DATA;
          issue(12, 0, RT_CMD12);
        end
      end
      PH_CSD: begin
        if (bidx < 16) csd[bidx[3:0]] = rx;
        bidx++;
        if (bidx < 18) clk_ph(PH_CSD);
        else begin
          decode_csd(); init_ok();
        end
      end
      PH_RDATA: begin
        if (bidx < 512) begin
          r.has = 1; r.rv = 1; r.rb = rx;
        end
        bidx++;
        if (bidx < 514) begin
          clk_ph(PH_RDATA);
          return;
        end
        bleft--;
        if (fcmd == 17) close_req(1, sdh_pkg::ERR_NONE);
        else if (bleft != 0) start_token();
        else issue(12, 0, RT_CMD12);
      end
      PH_W_RDY: begin
        if (rx == 8'hFF) begin
          ph = PH_W_TOK; send(wr_token());
        end else if (pms == 0) wblock_fail(sdh_pkg::ERR_BUSY);
        else clk_ph(PH_W_RDY);
      end
      PH_W_TOK: begin
        if (wr_token() == sdh_pkg::TOK_STOP) begin
          if (rfail) close_req(0, sdh_pkg::ERR_NONE);
          else begin
            pms = c_rdy_to; clk_ph(PH_W_FIN);
          end
        end else begin
          bidx = 0; ph = PH_W_REQ; r.has = 1; r.ww = 1;
        end
      end
      PH_W_DATA: begin
        bidx++;
        if (bidx < 512) begin
          ph = PH_W_REQ; r.has = 1; r.ww = 1;
        end else clk_ph(PH_W_TAIL);
      end
      PH_W_TAIL: begin
        if (bidx < 514) begin
          bidx++; clk_ph(PH_W_TAIL);
          return;
        end
        if (rx[4:0] == sdh_pkg::DRESP_MASK_OK) begin
          bleft--;
          if (fcmd == 24) begin
            pms = c_rdy_to; clk_ph(PH_W_FIN);
          end else begin_block();
        end else wblock_fail(sdh_pkg::ERR_DATA);
      end
      PH_W_FIN: begin
        if (rx == 8'hFF || pms == 0) close_req(1, sdh_pkg::ERR_NONE);
        else clk_ph(PH_W_FIN);
      end
      default: ;
    endcase
  endfunction

  function automatic void start_xfer(logic [31:0] lba, logic [15:0] cnt, logic wr);
    if (!rdyf || cnt == 0 || {16'd0, cnt} > sdh_pkg::MAX_COUNT) begin
      r.has = 1; r.done = 1; r.succ = 0; errc = sdh_pkg::ERR_REJECTED;
      return;
    end
    errc = sdh_pkg::ERR_NONE; rfail = 0;
    caddr = hc ? lba : {lba[22:0], 9'd0};
    bleft = cnt; cs = 1;
    if (!wr) issue(cnt == 1 ? 6'd17 : 6'd18, caddr, RT_RDCMD);
    else if (cnt == 1) issue(24, caddr, RT_WRCMD);
    else issue(23, {16'd0, cnt}, RT_A23);
  endfunction

  // advance the engine copy by one step and queue its result, if any
  function automatic void predict_step(step_t s);
    r = '0;
    case (s.cmd)
      sdh_pkg::CMD_TICK: begin
        if (msc != 0) msc--;
        if (pms != 0) pms--;
        if (msc == 0 && ph == PH_I_PWR) enter_clocks(PH_I_CLK);
        else if (msc == 0 && ph == PH_I_RDLY) enter_clocks(PH_I_RCLK);
      end
      sdh_pkg::CMD_RX: on_card_byte(s.rx);
      sdh_pkg::CMD_WDATA: if (ph == PH_W_REQ) begin
        ph = PH_W_DATA; send(s.wb);
      end
      sdh_pkg::CMD_INIT: if (ph == PH_IDLE) begin
        rdyf = 0; errc = sdh_pkg::ERR_NONE; slow = 1; cs = 0; rfail = 0;
        msc = {8'd0, c_pdly}; ph = PH_I_PWR;
        if (msc == 0) enter_clocks(PH_I_CLK);
      end
      sdh_pkg::CMD_READ, sdh_pkg::CMD_WRITE: begin
        if (ph == PH_IDLE) start_xfer(s.lba, s.cnt, s.cmd == sdh_pkg::CMD_WRITE);
      end
      default: ;
    endcase
    if (!r.has) return;
    if (!r.txv) begin
      r.cs = cs; r.slow = slow; r.tx = 0;
    end
    if (!r.rv) r.rb = 0;
    if (!r.done) r.succ = 0;
    r.err = errc; r.rdy = rdyf; r.cap = cap;
    expect_q.push_back(r);
  endfunction

  // what an emulated card answers in the current engine phase
  function automatic logic [7:0] card_answer();
    int unsigned p;
    p = $urandom_range(99);
    case (ph)
      PH_FR_RDY: return p < 90 ? 8'hFF : 8'($urandom);
      PH_FR_SEND: return 8'hFF;
      PH_FR_POLL: begin
        if (p < 25) return {1'b1, 7'($urandom)};
        if (app) return 8'($urandom_range(1));
        case (ret)
          RT_CMD0: return p < 85 ? 8'h01 : 8'h00;
          RT_CMD8: return p < 70 ? 8'h01 : 8'h05;
          RT_A41V2, RT_V1LOOP: return p < 60 ? 8'h00 : 8'h01;
          RT_V1PROBE: return p < 60 ? 8'($urandom_range(1)) : 8'h05;
          default: return p < 90 ? 8'h00 : 8'($urandom_range(127));
        endcase
      end
      PH_I_R7: begin
        if (p < 8) return 8'($urandom);
        return bidx == 2 ? 8'h01 : (bidx == 3 ? 8'hAA : 8'h00);
      end
      PH_I_OCR: return bidx == 0 ? (p < 50 ? 8'hC0 : 8'h80) : 8'($urandom);
      PH_TOK: return p < 75 ? sdh_pkg::TOK_START : (p < 92 ? 8'hFF : 8'($urandom));
      PH_CSD: begin
        if (bidx == 0) return p < 50 ? 8'h40 : 8'h00;
        if (bidx == 5) return {4'($urandom), 4'($urandom_range(9, 11))};
        return 8'($urandom);
      end
      PH_W_RDY: return p < 85 ? 8'hFF : 8'($urandom);
      PH_W_TAIL: begin
        if (bidx >= 514 && p < 85) return {3'($urandom), 5'h05};
        return 8'($urandom);
      end
      PH_W_FIN: return p < 70 ? 8'hFF : 8'($urandom);
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic step_t next_step();
    step_t s;
    int unsigned p;
    s.cmd = sdh_pkg::CMD_RX; s.lba = $urandom; s.cnt = 16'($urandom); s.rx = 8'($urandom);
    s.wb = 8'($urandom);
    p = $urandom_range(99);
    if (p < 4) begin
      s.cmd = 3'($urandom);
      return s;
    end
    case (ph)
      PH_IDLE: begin
        if (p < 10) s.cmd = sdh_pkg::CMD_TICK;
        else if (!rdyf || p < 18) s.cmd = sdh_pkg::CMD_INIT;
        else begin
          s.cmd = ($urandom_range(1) != 0) ? sdh_pkg::CMD_WRITE : sdh_pkg::CMD_READ;
          p = $urandom_range(99);
          if (p < 85) s.cnt = 16'($urandom_range(1, 3));
          else if (p < 95) s.cnt = 0;
        end
      end
      PH_I_PWR, PH_I_RDLY: s.cmd = sdh_pkg::CMD_TICK;
      PH_W_REQ: s.cmd = sdh_pkg::CMD_WDATA;
      default: begin
        if (p < 10) s.cmd = sdh_pkg::CMD_TICK;
        else s.rx = card_answer();
      end
    endcase
    return s;
  endfunction

  task automatic push_step(step_t s);
    while (step_q.size() > 16) @(posedge clk_i);
    predict_step(s);
    step_q.push_back(s);
  endtask

  task automatic wait_quiet();
    while (step_q.size() != 0 || s_valid || expect_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [sdh_pkg::CFG_IDX_W-1:0] idx, logic [15:0] val);
    @(posedge clk_i);
    cfg_valid <= 1'b1; cfg_index <= idx; cfg_data <= val;
    do @(posedge clk_i); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      sdh_pkg::CFG_READY_TO:   c_rdy_to = val;
      sdh_pkg::CFG_TOKEN_TO:   c_tok_to = val;
      sdh_pkg::CFG_INIT_TO:    c_init_to = val;
      sdh_pkg::CFG_IDLE_ATT:   c_att = val[7:0];
      sdh_pkg::CFG_RESP_POLLS: c_polls = val[7:0];
      sdh_pkg::CFG_RETRY_DLY:  c_rdly = val[7:0];
      sdh_pkg::CFG_PWR_DLY:    c_pdly = val[7:0];
      default: ;
    endcase
  endtask

  // mode 0: all minimums, mode 1: all maximums, otherwise mixed
  task automatic program_regs(int mode);
    int unsigned m;
    for (int i = 0; i < 7; i++) begin
      m = (mode < 2) ? mode : $urandom_range(3);
      if (i < 3) begin
        write_reg(IDX_W'(i), m == 0 ? 16'd0 : (m == 1 ? 16'hFFFF : 16'($urandom_range(1, 6))));
      end else if (i < 5) begin
        write_reg(IDX_W'(i), m == 0 ? 16'd1 : (m == 1 ? 16'd255 : 16'($urandom_range(2, 5))));
      end else begin
        write_reg(IDX_W'(i), m == 0 ? 16'd0 : (m == 1 ? 16'd255 : 16'($urandom_range(1, 4))));
      end
    end
  endtask

  task automatic directed_part();
    step_t s;
    s = '{cmd: sdh_pkg::CMD_READ, lba: 32'hFFFF_FFFF, cnt: 16'd1, rx: 8'h00, wb: 8'h00};
    push_step(s);
    s.cmd = sdh_pkg::CMD_WRITE; s.cnt = 16'hFFFF; push_step(s);
    s.cmd = sdh_pkg::CMD_RX; s.rx = 8'hFF; push_step(s);
    s.cmd = sdh_pkg::CMD_WDATA; s.wb = 8'hFF; push_step(s);
    s.cmd = 3'd6; push_step(s);
    s.cmd = 3'd7; push_step(s);
    s.cmd = sdh_pkg::CMD_TICK; push_step(s);
    s.cmd = sdh_pkg::CMD_INIT; push_step(s);
    s.cmd = sdh_pkg::CMD_INIT; push_step(s);
    s.cmd = sdh_pkg::CMD_READ; s.cnt = 0; push_step(s);
  endtask

  initial begin
    eng_reset();
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    program_regs(2);
    directed_part();
    for (int n = 0; n < N_STEPS; n++) begin
      if (n % 200 == 199 && ph == PH_IDLE) begin
        wait_quiet();
        program_regs(n < 400 ? 0 : (n < 600 ? 1 : 2));
        if (n >= 1000) begin
          write_reg(sdh_pkg::CFG_RESP_POLLS, 16'd10);
          write_reg(sdh_pkg::CFG_INIT_TO, 16'd1000);
        end
      end
      push_step(next_step());
    end
    wait_quiet();
    $display("run: %0d requests ended (%0d successful), %0d read bytes, %0d write byte requests",
             n_done, n_ok, n_rd, n_wr);
    if (err_cnt == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

  // sender: bursts with random gaps
  int unsigned burst_left = 1;
  int unsigned gap_left = 0;
  always @(posedge clk_i or negedge rst_ni) begin : drv
    step_t s;
    if (!rst_ni) begin
      s_valid <= 1'b0;
    end else if (!s_valid || s_ready) begin
      if (gap_left != 0) begin
        gap_left <= gap_left - 1;
        s_valid <= 1'b0;
      end else if (step_q.size() != 0) begin
        s = step_q.pop_front();
        s_valid <= 1'b1;
        s_data <= {s.wb, s.rx, s.cnt, s.lba};
        s_user <= s.cmd;
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 24);
          gap_left <= ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 6);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        s_valid <= 1'b0;
      end
    end
  end

  // receiver: stall modes of random length
  int unsigned stall_mode = 0;
  int unsigned stall_len = 0;
  int unsigned stall_tick = 0;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_ready <= 1'b0;
    end else begin
      stall_tick <= stall_tick + 1;
      if (stall_len == 0) begin
        stall_mode <= $urandom_range(3);
        stall_len <= $urandom_range(20, 200);
      end else begin
        stall_len <= stall_len - 1;
      end
      case (stall_mode)
        0, 1: m_ready <= 1'b1;
        2: m_ready <= ($urandom_range(1) != 0);
        default: m_ready <= (stall_tick % 4 == 0);
      endcase
    end
  end

  function automatic void check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected %0h, got %0h", name, exp_v, act_v);
      err_cnt++;
    end
  endfunction

  always @(posedge clk_i) begin : mon
    sdh_pkg::res_t e;
    if (rst_ni && m_valid && m_ready) begin
      if (expect_q.size() == 0) begin
        $error("result transaction with nothing expected: tdata %0h", m_data);
        err_cnt++;
      end else begin
        e = expect_q.pop_front();
        check_field("tx_valid", e.txv, m_data[0]);
        check_field("tx_byte", e.tx, m_data[8:1]);
        check_field("chip_select", e.cs, m_data[9]);
        check_field("slow_clock", e.slow, m_data[10]);
        check_field("read_valid", e.rv, m_data[11]);
        check_field("read_byte", e.rb, m_data[19:12]);
        check_field("write_wanted", e.ww, m_data[20]);
        check_field("done_res", e.done, m_last);
        check_field("success", e.succ, m_data[21]);
        check_field("error_code", e.err, m_data[24:22]);
        check_field("card_up", e.rdy, m_data[25]);
        check_field("capacity_blocks", e.cap, m_data[57:26]);
        if (e.done) n_done++;
        if (e.done && e.succ) n_ok++;
        if (e.rv) n_rd++;
        if (e.ww) n_wr++;
      end
    end
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles, expect_q.size());
      $display("testbench: errors");
      $finish;
    end
  end

endmodule

### sim.f
rtl/sdh_pkg.sv
rtl/sdh_cfg.sv
rtl/sdh_core.sv
rtl/sd_card_spi_host_engine.sv
tb/sv/testbench.sv
